### rtl/assert_macros.svh
// Shared assertion macros for the merger checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TWM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("twm assertion failed");

// Checked at every edge, reset included.
`define TWM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("twm assertion failed");

`endif

### rtl/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Types and constants of the time window hit merger.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int MaxHits  = 64;
  localparam int AddrW    = $clog2(MaxHits);
  localparam int CntW     = $clog2(MaxHits + 1);
  localparam int VolW     = 10;
  localparam int TimeW    = 31;
  localparam int EnW      = 24;
  localparam int SumW     = 30;
  localparam int WinW     = 20;
  localparam logic [WinW-1:0] WinReset = 20'd20000;

  typedef struct packed {
    logic [VolW-1:0]  vol;
    logic [TimeW-1:0] tim;
    logic [EnW-1:0]   en;
  } hit_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    hit_t             data;
  } ram_wr_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FIND,
    ST_GROUP,
    ST_EMIT
  } state_t;

endpackage

### rtl/twm_hit_if.sv
// ----------------------------------------------------------------------------
// twm_hit_if
// Channel interfaces: input hits, merged results and configuration writes.
// ----------------------------------------------------------------------------
interface twm_hit_if;
  logic               valid;
  logic               ready;
  logic [9:0]         volume_id;
  logic signed [31:0] hit_time;
  logic [23:0]        energy;
  logic               last_hit;
  modport source (output valid, volume_id, hit_time, energy, last_hit, input ready);
  modport sink (input valid, volume_id, hit_time, energy, last_hit, output ready);
endinterface

interface twm_res_if;
  logic        valid;
  logic        ready;
  logic [9:0]  merged_volume;
  logic [30:0] merged_time;
  logic [29:0] merged_energy;
  logic        overflowed;
  logic        last_result;
  modport source (output valid, merged_volume, merged_time, merged_energy, overflowed,
                  last_result, input ready);
  modport sink (input valid, merged_volume, merged_time, merged_energy, overflowed,
                last_result, output ready);
endinterface

interface twm_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/twm_hit_ram.sv
// ----------------------------------------------------------------------------
// twm_hit_ram
// Hit buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module twm_hit_ram
  import twm_pkg::*;
(
  input  logic             clk,
  input  ram_wr_t          wr,
  input  logic [AddrW-1:0] raddr,
  output hit_t             rdata
);

  hit_t mem [MaxHits];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/time_window_hit_merger.sv
// ----------------------------------------------------------------------------
// time_window_hit_merger
// Per-volume coincidence-window merging of detector hits.
// ----------------------------------------------------------------------------
// Hits arrive on in_bus, one beat per cycle while the block is loading. Hits
// with negative time are dropped; hits beyond 64 are dropped and flagged.
// A beat with last_hit starts the merge if a hit is stored; in_bus.ready stays
// low until the last merged result has been taken on out_bus.
// Each merged result needs two sweeps of the hit buffer: one finds the
// earliest remaining hit (time, then volume), the other sums every remaining
// hit of that volume within cfg window of it. Both sweeps read the stored
// hits one after another through the single buffer read port.
// A result is held on out_bus until it is taken; a stalled receiver stalls
// the merge. cfg_bus writes the 20-bit merge window and is always ready; it
// must be written only while idle, which the block itself does not enforce.
// Synchronous reset clears the run state and sets the window to 20000 ps;
// the buffer contents are not cleared.
// ----------------------------------------------------------------------------
module time_window_hit_merger
  import twm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  twm_hit_if.sink   in_bus,
  twm_res_if.source out_bus,
  twm_cfg_if.sink   cfg_bus
);

  state_t state_r, state_nxt;

  logic [WinW-1:0]    win_r;
  logic [CntW-1:0]    cnt_r, rem_r, gcnt_r;
  logic               ovf_r;
  logic [MaxHits-1:0] used_r;
  logic [CntW-1:0]    ptr_r;
  logic               rv_r;
  logic [AddrW-1:0]   ra_r;
  logic               best_v_r, last_r;
  logic [VolW-1:0]    best_vol_r;
  logic [TimeW-1:0]   best_time_r;
  logic [SumW-1:0]    sum_r;

  ram_wr_t wr;
  hit_t    rdata;

  logic            in_fire, keep, sweeping, issue, sweep_done, live, in_grp, better;
  logic [CntW-1:0] cnt_after, cnt_m1, rem_left;
  logic [TimeW-1:0] tdiff;

  twm_hit_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (ptr_r[AddrW-1:0]),
    .rdata (rdata)
  );

  assign in_fire   = in_bus.valid && in_bus.ready;
  assign keep      = !in_bus.hit_time[31] && (cnt_r != CntW'(MaxHits));
  assign cnt_after = cnt_r + CntW'(keep);
  assign cnt_m1    = cnt_r - CntW'(1);
  assign issue     = sweeping && (ptr_r < cnt_r);
  assign sweep_done = rv_r && ({1'b0, ra_r} == cnt_m1);
  assign live      = rv_r && !used_r[ra_r];
  assign better    = !best_v_r || ({rdata.tim, rdata.vol} < {best_time_r, best_vol_r});
  assign tdiff     = rdata.tim - best_time_r;
  assign in_grp    = live && (rdata.vol == best_vol_r) && (tdiff <= TimeW'(win_r));
  assign rem_left  = rem_r - gcnt_r;

  always_comb begin
    wr.en   = in_fire && keep;
    wr.addr = cnt_r[AddrW-1:0];
    wr.data = '{vol: in_bus.volume_id, tim: in_bus.hit_time[TimeW-1:0],
                en: in_bus.energy};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_bus.last_hit && (cnt_after != '0)) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (sweep_done) state_nxt = ST_GROUP;
      end
      ST_GROUP: begin
        if (sweep_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_bus.ready) state_nxt = last_r ? ST_LOAD : ST_FIND;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    in_bus.ready  = (state_r == ST_LOAD);
    out_bus.valid = (state_r == ST_EMIT);
    sweeping      = (state_r == ST_FIND) || (state_r == ST_GROUP);
    cfg_bus.ready = 1'b1;
    out_bus.merged_volume = best_vol_r;
    out_bus.merged_time   = best_time_r;
    out_bus.merged_energy = sum_r;
    out_bus.overflowed    = ovf_r;
    out_bus.last_result   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      win_r    <= WinReset;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      rv_r     <= 1'b0;
      ptr_r    <= '0;
      best_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid) win_r <= cfg_bus.data;
      rv_r <= issue;
      ra_r <= ptr_r[AddrW-1:0];
      if (issue) ptr_r <= ptr_r + CntW'(1);

      unique case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            cnt_r <= cnt_after;
            if (!in_bus.hit_time[31] && !keep) ovf_r <= 1'b1;
            if (in_bus.last_hit) begin
              if (cnt_after == '0) ovf_r <= 1'b0;
              used_r   <= '0;
              rem_r    <= cnt_after;
              ptr_r    <= '0;
              best_v_r <= 1'b0;
            end
          end
        end
        ST_FIND: begin
          if (live && better) begin
            best_v_r    <= 1'b1;
            best_vol_r  <= rdata.vol;
            best_time_r <= rdata.tim;
          end
          if (sweep_done) begin
            ptr_r  <= '0;
            sum_r  <= '0;
            gcnt_r <= '0;
          end
        end
        ST_GROUP: begin
          // Sum and retire every remaining hit of the group.
          if (in_grp) begin
            sum_r  <= sum_r + SumW'(rdata.en);
            gcnt_r <= gcnt_r + CntW'(1);
            used_r[ra_r] <= 1'b1;
          end
          if (sweep_done) last_r <= ((rem_r - gcnt_r - CntW'(in_grp)) == '0);
        end
        ST_EMIT: begin
          if (out_bus.ready) begin
            rem_r    <= rem_left;
            best_v_r <= 1'b0;
            ptr_r    <= '0;
            if (last_r) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/twm_checker.sv
// ----------------------------------------------------------------------------
// twm_checker
// Port-level checks of the merger, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twm_checker
  import twm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // A result beat waits for the receiver.
  `TWM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // The block never loads hits while a result is pending.
  `TWM_ASSERT(a_excl, clk, rst_n, in_ready |-> !out_valid)
  // After a result that is not the last, the merge goes on and loading stays off.
  `TWM_ASSERT(a_more, clk, rst_n, out_valid && out_ready && !out_last |=> !in_ready)
  // Reset leaves no result pending.
  `TWM_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid)

endmodule

bind time_window_hit_merger twm_checker u_twm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_last  (out_bus.last_result)
);
